>>> src/mfbdr_pkg.sv
// ----------------------------------------------------------------------------
// mfbdr_pkg: shared types and constants of the boost duty regulator
// Field widths, register indexes, register reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbdr_pkg;

   // field widths
   localparam int SAMPLE_W  = 12;
   localparam int DUTY_W    = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_CODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_CODE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_UP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DOWN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_WRAP    = 3'd6;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_TARGET_CODE = 12'd2482;
   localparam logic [SAMPLE_W-1:0] RST_CLAMP_CODE  = 12'd2820;
   localparam logic [SAMPLE_W-1:0] RST_READY_CODE  = 12'd2234;
   localparam logic [DUTY_W-1:0]   RST_DUTY_MAX    = 16'd47186;
   localparam logic [DUTY_W-1:0]   RST_STEP_UP     = 16'd79;
   localparam logic [DUTY_W-1:0]   RST_STEP_DOWN   = 16'd328;
   localparam logic [DUTY_W-1:0]   RST_PWM_WRAP    = 16'd3000;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DUTY,
      ST_MULT
   } state_type;

endpackage

`default_nettype wire

>>> src/median_filtered_boost_duty_regulator.sv
// ----------------------------------------------------------------------------
// median_filtered_boost_duty_regulator: median-of-window boost duty regulator
// Collects ADC samples into windows, takes each window's median and ramps the
// boost duty against target and clamp levels, one result per full window.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one ADC sample and the run bit per request. A
//   request that does not complete a window is stored and gives no result.
//   The request that completes a window starts the sequencer: a median
//   search over the stored samples with one rank comparator bank, one
//   candidate per cycle, then a duty update step and a PWM compare
//   multiply step. req_stall is high after that request until the multiply
//   step has loaded its result, which waits while an old result is held.
//   The result sits in an output register on the rsp_ channel. While it is
//   held by rsp_stall, samples that do not complete a window are still
//   taken; the next window waits in its multiply step until the old result
//   has gone.
//   Synchronous reset clears the window count, the duty and the output
//   valid, and loads the register defaults. The csr_ port writes a register
//   from csr_wdata; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filtered_boost_duty_regulator
   import mfbdr_pkg::*;
#(
   parameter int WINDOW_LEN = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   // sample requests
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [SAMPLE_W-1:0]  req_sample,
   input  wire logic                 req_run,
   // window results
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DUTY_W-1:0]         rsp_pwm_compare,
   output logic [DUTY_W-1:0]         rsp_duty,
   output logic [SAMPLE_W-1:0]       rsp_median_code,
   output logic                      rsp_over_voltage,
   output logic                      rsp_ready_res
);

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
   localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW_LEN / 2);

   // configuration registers
   logic [SAMPLE_W-1:0] target_code_ff, clamp_code_ff, ready_code_ff;
   logic [DUTY_W-1:0]   duty_max_ff, step_up_ff, step_down_ff, pwm_wrap_ff;

   // window and regulator state
   logic [SAMPLE_W-1:0] window_store [WINDOW_LEN];
   logic [IDX_W-1:0]    window_count_ff, window_count_in;
   logic [DUTY_W-1:0]   duty_level_ff;
   logic                run_ff;
   logic [IDX_W-1:0]    cand_ff;
   logic [SAMPLE_W-1:0] med_ff;
   logic                ov_ff, rdy_ff;

   // output registers
   logic                rsp_valid_ff;
   logic [DUTY_W-1:0]   rsp_pwm_compare_ff, rsp_duty_ff;
   logic [SAMPLE_W-1:0] rsp_median_code_ff;
   logic                rsp_over_voltage_ff, rsp_ready_res_ff;

   state_type state_ff, state_in;

   logic req_take, window_done, scan_found, out_free, out_load;

   // ------------------------------------------------------------------------
   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_code_ff <= RST_TARGET_CODE;
         clamp_code_ff  <= RST_CLAMP_CODE;
         ready_code_ff  <= RST_READY_CODE;
         duty_max_ff    <= RST_DUTY_MAX;
         step_up_ff     <= RST_STEP_UP;
         step_down_ff   <= RST_STEP_DOWN;
         pwm_wrap_ff    <= RST_PWM_WRAP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_CODE: target_code_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_CLAMP_CODE:  clamp_code_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_READY_CODE:  ready_code_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_DUTY_MAX:    duty_max_ff    <= csr_wdata[DUTY_W-1:0];
            CSR_STEP_UP:     step_up_ff     <= csr_wdata[DUTY_W-1:0];
            CSR_STEP_DOWN:   step_down_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_PWM_WRAP:    pwm_wrap_ff    <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // request intake and window store
   assign req_take    = req_valid && !req_stall;
   assign window_done = (window_count_ff == LAST_IDX);

   always_comb begin
      window_count_in = window_count_ff;
      if (req_take) begin
         window_count_in = window_done ? '0 : window_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         window_store[window_count_ff] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
      end else begin
         window_count_ff <= window_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // rank comparator bank: counts of entries below and not above the candidate
   logic [SAMPLE_W-1:0]   cand_val;
   logic [WINDOW_LEN-1:0] lt_vec, le_vec;
   logic [CNT_W-1:0]      lt_cnt, le_cnt;

   assign cand_val = window_store[cand_ff];

   always_comb begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
         lt_vec[j] = window_store[j] <  cand_val;
         le_vec[j] = window_store[j] <= cand_val;
      end
   end

   assign lt_cnt     = CNT_W'($countones(lt_vec));
   assign le_cnt     = CNT_W'($countones(le_vec));
   assign scan_found = (lt_cnt <= MID_RANK) && (le_cnt > MID_RANK);

   // ------------------------------------------------------------------------
   // duty update from the median
   logic                ov_now;
   logic [DUTY_W:0]     d_up, d_step;
   logic [DUTY_W-1:0]   d_dn, d_sat, d_new;

   assign ov_now = med_ff > clamp_code_ff;
   assign d_up   = {1'b0, duty_level_ff} + {1'b0, step_up_ff};
   assign d_dn   = (duty_level_ff > step_down_ff) ? duty_level_ff - step_down_ff : '0;
   assign d_step = (med_ff < target_code_ff) ? d_up : {1'b0, d_dn};
   assign d_sat  = (d_step > {1'b0, duty_max_ff}) ? duty_max_ff : d_step[DUTY_W-1:0];
   assign d_new  = (ov_now || !run_ff) ? '0 : d_sat;

   // PWM compare: (1 - duty) scaled by the wrap
   logic [DUTY_W:0]     inv_duty;
   logic [2*DUTY_W:0]   pwm_prod;

   assign inv_duty = {1'b1, {DUTY_W{1'b0}}} - {1'b0, duty_level_ff};
   assign pwm_prod = (2*DUTY_W+1)'(inv_duty) * (2*DUTY_W+1)'(pwm_wrap_ff);

   // ------------------------------------------------------------------------
   // sequencer: next state
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take && window_done) state_in = ST_SCAN;
         ST_SCAN: if (scan_found) state_in = ST_DUTY;
         ST_DUTY: state_in = ST_MULT;
         ST_MULT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_MULT: out_load  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // datapath registers: candidate, median, run bit, flags
   always_ff @(posedge clock) begin
      if (req_take && window_done) begin
         run_ff  <= req_run;
         cand_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (scan_found) begin
            med_ff <= cand_val;
         end else begin
            cand_ff <= cand_ff + 1'b1;
         end
      end
      if (state_ff == ST_DUTY) begin
         ov_ff  <= ov_now;
         rdy_ff <= med_ff >= ready_code_ff;
      end
   end

   // duty level
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_level_ff <= '0;
      end else if (state_ff == ST_DUTY) begin
         duty_level_ff <= d_new;
      end
   end

   // ------------------------------------------------------------------------
   // result register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pwm_compare_ff  <= pwm_prod[2*DUTY_W-1:DUTY_W];
         rsp_duty_ff         <= duty_level_ff;
         rsp_median_code_ff  <= med_ff;
         rsp_over_voltage_ff <= ov_ff;
         rsp_ready_res_ff    <= rdy_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_compare  = rsp_pwm_compare_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_median_code  = rsp_median_code_ff;
   assign rsp_over_voltage = rsp_over_voltage_ff;
   assign rsp_ready_res    = rsp_ready_res_ff;

   // ------------------------------------------------------------------------
   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      window_count_ff <= LAST_IDX)
      else $error("window count beyond window length");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (cand_ff == LAST_IDX) |=> (state_ff != ST_SCAN))
      else $error("median search ran past the last candidate");

   a_ov_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_over_voltage_ff |-> (rsp_duty_ff == '0))
      else $error("over-voltage result with non-zero duty");

endmodule

`default_nettype wire
